// ===== design/dpf_pkg.sv =====
package dpf_pkg;

	// field widths
	localparam int COORD_W  = 32;
	localparam int SS_W     = 31;
	localparam int DF_W     = 16;
	localparam int PITCH_W  = 16;

	// internal widths
	localparam int MAG_W    = COORD_W + 1;          // |difference| of two coordinates
	localparam int POS_W    = 6;                    // index of leading one in MAG_W bits
	localparam int NORM_W   = 24;                   // normalised magnitude
	localparam int NORM_MSB = NORM_W - 1;
	localparam int LEN_W    = 25;                   // vector length after square root
	localparam int SUMSQ_W  = 2 * LEN_W;            // sum of squares
	localparam int DOT_W    = 57;                   // |dot product|
	localparam int QD_W     = 34;                   // projection quotient bits
	localparam int CAP_W    = SS_W + 8;             // sound_speed * 256
	localparam int VEL_W    = CAP_W + 1;            // capped signed projection
	localparam int PROD_W   = DF_W + 1 + VEL_W;     // doppler_scale * projection
	localparam int ND_W     = 52;                   // numerator and denominator
	localparam int PQ_W     = PITCH_W;              // pitch quotient bits

	localparam logic [SS_W-1:0]    SOUND_SPEED_RST = 31'd140615680;
	localparam logic [PITCH_W-1:0] PITCH_ONE = 16'd16384;
	localparam logic [PITCH_W-1:0] PITCH_MIN = 16'd8192;
	localparam logic [PITCH_W-1:0] PITCH_MAX = 16'd32768;

	typedef enum logic [3:0] {
		CFG_LPOS_X   = 4'd0,
		CFG_LPOS_Y   = 4'd1,
		CFG_LPOS_Z   = 4'd2,
		CFG_LVEL_X   = 4'd3,
		CFG_LVEL_Y   = 4'd4,
		CFG_LVEL_Z   = 4'd5,
		CFG_SPEED    = 4'd6,
		CFG_DOPPLER  = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] src_pos_x;
		logic signed [COORD_W-1:0] src_pos_y;
		logic signed [COORD_W-1:0] src_pos_z;
		logic signed [COORD_W-1:0] src_vel_x;
		logic signed [COORD_W-1:0] src_vel_y;
		logic signed [COORD_W-1:0] src_vel_z;
	} src_t;

	typedef struct packed {
		logic [PITCH_W-1:0] pitch_factor;
		logic               clamped;
	} res_t;

	// sideband alongside the square root cells
	typedef struct packed {
		logic             zero;
		logic             l_neg;
		logic             s_neg;
		logic [DOT_W-1:0] l_abs;
		logic [DOT_W-1:0] s_abs;
	} sqrt_sb_t;

	// sideband alongside the projection divider cells
	typedef struct packed {
		logic zero;
		logic l_neg;
		logic s_neg;
	} div_sb_t;

	// sideband alongside the pitch divider cells
	typedef struct packed {
		logic zero;
		logic sat_hi;
		logic sat_lo;
	} pq_sb_t;

endpackage

// ===== design/dpf_div_cell.sv =====
// One restoring division step: bring down a dividend bit, subtract when it fits.
module dpf_div_cell #(
	parameter int DW = dpf_pkg::LEN_W,
	parameter int NW = dpf_pkg::QD_W
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,
	input  logic [DW-1:0] dvs_in,
	input  logic [NW-1:0] nq_in,
	output logic [DW-1:0] rem_q,
	output logic [DW-1:0] dvs_q,
	output logic [NW-1:0] nq_q
);

	logic [DW:0]   t;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_n;

	always_comb begin
		t     = {rem_in, nq_in[NW-1]};
		diff  = t - {1'b0, dvs_in};
		ge    = (t >= {1'b0, dvs_in});
		rem_n = ge ? diff[DW-1:0] : t[DW-1:0];
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_n;
		dvs_q <= dvs_in;
		nq_q  <= {nq_in[NW-2:0], ge};
	end

endmodule

// ===== design/dpf_sqrt_cell.sv =====
// One digit of a restoring square root: bring down two radicand bits.
module dpf_sqrt_cell #(
	parameter int RW = dpf_pkg::LEN_W,
	parameter int XW = dpf_pkg::SUMSQ_W
) (
	input  logic          clk,
	input  logic [RW+1:0] rem_in,
	input  logic [RW-1:0] root_in,
	input  logic [XW-1:0] x_in,
	output logic [RW+1:0] rem_q,
	output logic [RW-1:0] root_q,
	output logic [XW-1:0] x_q
);

	logic [RW+3:0] t;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;
	logic [RW+1:0] rem_n;

	always_comb begin
		t     = {rem_in, x_in[XW-1:XW-2]};
		trial = {2'b00, root_in, 2'b01};
		diff  = t - trial;
		ge    = (t >= trial);
		rem_n = ge ? diff[RW+1:0] : t[RW+1:0];
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_n;
		root_q <= {root_in[RW-2:0], ge};
		x_q    <= {x_in[XW-3:0], 2'b00};
	end

endmodule

// ===== design/doppler_pitch_factor.sv =====
// Doppler pitch factor, one source query per transaction.
// Pipeline: 85 register stages from the accepting edge to the done strobe.
// Throughput: one transaction every cycle; busy never rises. The depth comes mostly from the
// square root (25 cells), the projection divider (34 cells) and the pitch divider (16 cells).
// Reset clears the pipeline valid line and loads the register defaults; no result follows
// reset until a transaction is accepted. The receiver cannot stall the done strobe.
module doppler_pitch_factor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  dpf_pkg::src_t        src,
	output logic                 done,
	output dpf_pkg::res_t        res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int CW    = dpf_pkg::COORD_W;
	localparam int MW    = dpf_pkg::MAG_W;
	localparam int NWID  = dpf_pkg::NORM_W;
	localparam int LW    = dpf_pkg::LEN_W;
	localparam int SQW   = dpf_pkg::SUMSQ_W;
	localparam int DTW   = dpf_pkg::DOT_W;
	localparam int QW    = dpf_pkg::QD_W;
	localparam int CPW   = dpf_pkg::CAP_W;
	localparam int VW    = dpf_pkg::VEL_W;
	localparam int PW    = dpf_pkg::PROD_W;
	localparam int NDW   = dpf_pkg::ND_W;
	localparam int PQW   = dpf_pkg::PQ_W;
	localparam int DFW   = dpf_pkg::DF_W;
	localparam int PRW   = 2 * LW - 2;          // width of one normalised square
	localparam int DOTX  = DTW + 2;             // dot sum with headroom
	localparam int NX    = PW + 1;              // numerator before saturation
	// valid line: front stages, sqrt cells, divider cells, back stages, pitch cells
	localparam int VLD_N = 5 + LW + QW + 4 + PQW;

	// -------------------------------------------------------------------------
	// Configuration registers; the port never holds a write off.
	// -------------------------------------------------------------------------
	logic signed [CW-1:0]          lpos_q [3];
	logic signed [CW-1:0]          lvel_q [3];
	logic [dpf_pkg::SS_W-1:0]      speed_q;
	logic [DFW-1:0]                scale_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lpos_q[i] <= '0;
				lvel_q[i] <= '0;
			end
			speed_q <= dpf_pkg::SOUND_SPEED_RST;
			scale_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dpf_pkg::CFG_LPOS_X:  lpos_q[0] <= cfg_data;
				dpf_pkg::CFG_LPOS_Y:  lpos_q[1] <= cfg_data;
				dpf_pkg::CFG_LPOS_Z:  lpos_q[2] <= cfg_data;
				dpf_pkg::CFG_LVEL_X:  lvel_q[0] <= cfg_data;
				dpf_pkg::CFG_LVEL_Y:  lvel_q[1] <= cfg_data;
				dpf_pkg::CFG_LVEL_Z:  lvel_q[2] <= cfg_data;
				dpf_pkg::CFG_SPEED:   speed_q   <= cfg_data[dpf_pkg::SS_W-1:0];
				dpf_pkg::CFG_DOPPLER: scale_q   <= cfg_data[DFW-1:0];
				default: ;   // drop writes to unknown indexes
			endcase
		end
	end

	// The user must change the registers only while nothing is in flight; the block does not
	// enforce it. Every stage reads them directly instead of carrying a copy along the pipe.
	logic [CPW-1:0] ss256;
	assign ss256 = {speed_q, 8'd0};

	// -------------------------------------------------------------------------
	// Valid line: one bit per stage, shifted every cycle.
	// -------------------------------------------------------------------------
	logic [VLD_N-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[VLD_N-2:0], start & ~busy};
		end
	end

	// -------------------------------------------------------------------------
	// Stage 1: listener minus source, magnitudes, largest magnitude.
	// -------------------------------------------------------------------------
	logic signed [CW-1:0] spos [3];
	logic signed [CW-1:0] svel [3];
	logic signed [MW-1:0] diff [3];
	logic [MW-1:0]        mag  [3];
	logic [MW-1:0]        mmax;

	assign spos[0] = src.src_pos_x;
	assign spos[1] = src.src_pos_y;
	assign spos[2] = src.src_pos_z;
	assign svel[0] = src.src_vel_x;
	assign svel[1] = src.src_vel_y;
	assign svel[2] = src.src_vel_z;

	always_comb begin
		mmax = '0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = {lpos_q[i][CW-1], lpos_q[i]} - {spos[i][CW-1], spos[i]};
			mag[i]  = diff[i][MW-1] ? (~diff[i] + 1'b1) : diff[i];
			if (mag[i] > mmax)
				mmax = mag[i];
		end
	end

	logic [MW-1:0]        mag_s1 [3];
	logic                 neg_s1 [3];
	logic signed [CW-1:0] sv_s1  [3];
	logic [MW-1:0]        max_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag[i];
			neg_s1[i] <= diff[i][MW-1];
			sv_s1[i]  <= svel[i];
		end
		max_s1 <= mmax;
	end

	// -------------------------------------------------------------------------
	// Stage 2: find the leading one of the largest magnitude.
	// -------------------------------------------------------------------------
	logic [dpf_pkg::POS_W-1:0] lead;

	always_comb begin
		lead = '0;
		for (int b = 0; b < MW; b++) begin
			if (max_s1[b])
				lead = dpf_pkg::POS_W'(b);
		end
	end

	logic [MW-1:0]             mag_s2 [3];
	logic                      neg_s2 [3];
	logic signed [CW-1:0]      sv_s2  [3];
	logic [dpf_pkg::POS_W-1:0] lead_s2;
	logic                      zero_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= mag_s1[i];
			neg_s2[i] <= neg_s1[i];
			sv_s2[i]  <= sv_s1[i];
		end
		lead_s2 <= lead;
		zero_s2 <= (max_s1 == '0);
	end

	// -------------------------------------------------------------------------
	// Stage 3: shift all three so the largest sits in [2^23, 2^24).
	// -------------------------------------------------------------------------
	logic [dpf_pkg::POS_W-1:0] rsh, lsh;
	logic [MW-1:0]             shifted [3];

	always_comb begin
		rsh = lead_s2 - dpf_pkg::POS_W'(dpf_pkg::NORM_MSB);
		lsh = dpf_pkg::POS_W'(dpf_pkg::NORM_MSB) - lead_s2;
		for (int i = 0; i < 3; i++) begin
			if (lead_s2 > dpf_pkg::POS_W'(dpf_pkg::NORM_MSB))
				shifted[i] = mag_s2[i] >> rsh;
			else
				shifted[i] = mag_s2[i] << lsh;
		end
	end

	logic [NWID-1:0]      nmag_s3 [3];
	logic                 neg_s3  [3];
	logic signed [CW-1:0] sv_s3   [3];
	logic                 zero_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nmag_s3[i] <= shifted[i][NWID-1:0];
			neg_s3[i]  <= neg_s2[i];
			sv_s3[i]   <= sv_s2[i];
		end
		zero_s3 <= zero_s2;
	end

	// -------------------------------------------------------------------------
	// Stage 4: squares and the six velocity products.
	// -------------------------------------------------------------------------
	logic signed [LW-1:0] dvec [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvec[i] = neg_s3[i] ? -$signed({1'b0, nmag_s3[i]}) : $signed({1'b0, nmag_s3[i]});
		end
	end

	logic [PRW-1:0]        sq_s4 [3];
	logic signed [DTW-1:0] pl_s4 [3];
	logic signed [DTW-1:0] ps_s4 [3];
	logic                  zero_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= nmag_s3[i] * nmag_s3[i];
			pl_s4[i] <= dvec[i] * lvel_q[i];
			ps_s4[i] <= dvec[i] * sv_s3[i];
		end
		zero_s4 <= zero_s3;
	end

	// -------------------------------------------------------------------------
	// Stage 5: sum of squares and both dot products, split into sign and size.
	// -------------------------------------------------------------------------
	logic signed [DOTX-1:0] dot_l, dot_s;
	logic [DOTX-1:0]        abs_l, abs_s;

	always_comb begin
		dot_l = DOTX'(pl_s4[0]) + DOTX'(pl_s4[1]) + DOTX'(pl_s4[2]);
		dot_s = DOTX'(ps_s4[0]) + DOTX'(ps_s4[1]) + DOTX'(ps_s4[2]);
		abs_l = dot_l[DOTX-1] ? -dot_l : dot_l;
		abs_s = dot_s[DOTX-1] ? -dot_s : dot_s;
	end

	logic [SQW-1:0]         sumsq_s5;
	dpf_pkg::sqrt_sb_t      sb_s5;

	always_ff @(posedge clk) begin
		sumsq_s5     <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
		sb_s5.zero   <= zero_s4;
		sb_s5.l_neg  <= dot_l[DOTX-1];
		sb_s5.s_neg  <= dot_s[DOTX-1];
		sb_s5.l_abs  <= abs_l[DTW-1:0];
		sb_s5.s_abs  <= abs_s[DTW-1:0];
	end

	// -------------------------------------------------------------------------
	// Square root: a row of cells, one root bit each.
	// -------------------------------------------------------------------------
	logic [LW+1:0]     sq_rem  [LW+1];
	logic [LW-1:0]     sq_root [LW+1];
	logic [SQW-1:0]    sq_x    [LW+1];
	dpf_pkg::sqrt_sb_t sq_sb_q [LW];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_x[0]    = sumsq_s5;

	for (genvar k = 0; k < LW; k++) begin : g_sqrt
		dpf_sqrt_cell #(
			.RW(LW),
			.XW(SQW)
		) u_cell (
			.clk    (clk),
			.rem_in (sq_rem[k]),
			.root_in(sq_root[k]),
			.x_in   (sq_x[k]),
			.rem_q  (sq_rem[k+1]),
			.root_q (sq_root[k+1]),
			.x_q    (sq_x[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sq_sb_q[0] <= sb_s5;
		for (int k = 1; k < LW; k++)
			sq_sb_q[k] <= sq_sb_q[k-1];
	end

	// -------------------------------------------------------------------------
	// Projections: |dot| / length in two divider rows sharing the divisor.
	// Length is at least 2^23 here, so the top dividend bits already sit below it.
	// -------------------------------------------------------------------------
	logic [LW-1:0]   dl_rem [QW+1];
	logic [LW-1:0]   dl_dvs [QW+1];
	logic [QW-1:0]   dl_nq  [QW+1];
	logic [LW-1:0]   ds_rem [QW+1];
	logic [LW-1:0]   ds_dvs [QW+1];
	logic [QW-1:0]   ds_nq  [QW+1];
	dpf_pkg::div_sb_t dv_sb_q [QW];

	assign dl_rem[0] = LW'(sq_sb_q[LW-1].l_abs[DTW-1:QW]);
	assign dl_dvs[0] = sq_root[LW];
	assign dl_nq[0]  = sq_sb_q[LW-1].l_abs[QW-1:0];
	assign ds_rem[0] = LW'(sq_sb_q[LW-1].s_abs[DTW-1:QW]);
	assign ds_dvs[0] = sq_root[LW];
	assign ds_nq[0]  = sq_sb_q[LW-1].s_abs[QW-1:0];

	for (genvar k = 0; k < QW; k++) begin : g_proj
		dpf_div_cell #(
			.DW(LW),
			.NW(QW)
		) u_cell_l (
			.clk   (clk),
			.rem_in(dl_rem[k]),
			.dvs_in(dl_dvs[k]),
			.nq_in (dl_nq[k]),
			.rem_q (dl_rem[k+1]),
			.dvs_q (dl_dvs[k+1]),
			.nq_q  (dl_nq[k+1])
		);
		dpf_div_cell #(
			.DW(LW),
			.NW(QW)
		) u_cell_s (
			.clk   (clk),
			.rem_in(ds_rem[k]),
			.dvs_in(ds_dvs[k]),
			.nq_in (ds_nq[k]),
			.rem_q (ds_rem[k+1]),
			.dvs_q (ds_dvs[k+1]),
			.nq_q  (ds_nq[k+1])
		);
	end

	always_ff @(posedge clk) begin
		dv_sb_q[0].zero  <= sq_sb_q[LW-1].zero;
		dv_sb_q[0].l_neg <= sq_sb_q[LW-1].l_neg;
		dv_sb_q[0].s_neg <= sq_sb_q[LW-1].s_neg;
		for (int k = 1; k < QW; k++)
			dv_sb_q[k] <= dv_sb_q[k-1];
	end

	// -------------------------------------------------------------------------
	// Velocity cap sound_speed*256 / doppler_scale. It depends on the registers
	// alone, so the row runs freely and has long settled before any transaction
	// that follows a register write reaches its output.
	// -------------------------------------------------------------------------
	localparam int CAP_CELLS = CPW;

	logic [DFW-1:0] cp_rem [CAP_CELLS+1];
	logic [DFW-1:0] cp_dvs [CAP_CELLS+1];
	logic [CPW-1:0] cp_nq  [CAP_CELLS+1];

	assign cp_rem[0] = '0;
	assign cp_dvs[0] = scale_q;
	assign cp_nq[0]  = ss256;

	for (genvar k = 0; k < CAP_CELLS; k++) begin : g_cap
		dpf_div_cell #(
			.DW(DFW),
			.NW(CPW)
		) u_cell (
			.clk   (clk),
			.rem_in(cp_rem[k]),
			.dvs_in(cp_dvs[k]),
			.nq_in (cp_nq[k]),
			.rem_q (cp_rem[k+1]),
			.dvs_q (cp_dvs[k+1]),
			.nq_q  (cp_nq[k+1])
		);
	end

	// -------------------------------------------------------------------------
	// Stage 65: restore signs and hold each projection at the cap.
	// -------------------------------------------------------------------------
	logic signed [VW-1:0] vl, vs, capx;

	always_comb begin
		capx = $signed({1'b0, cp_nq[CAP_CELLS]});
		vl   = dv_sb_q[QW-1].l_neg ? -$signed(VW'(dl_nq[QW])) : $signed(VW'(dl_nq[QW]));
		vs   = dv_sb_q[QW-1].s_neg ? -$signed(VW'(ds_nq[QW])) : $signed(VW'(ds_nq[QW]));
		if (vl > capx)
			vl = capx;
		if (vs > capx)
			vs = capx;
	end

	logic signed [VW-1:0] vl_s65, vs_s65;
	logic                 zero_s65;

	always_ff @(posedge clk) begin
		vl_s65   <= vl;
		vs_s65   <= vs;
		zero_s65 <= dv_sb_q[QW-1].zero;
	end

	// -------------------------------------------------------------------------
	// Stage 66: scale the projections by the doppler factor.
	// -------------------------------------------------------------------------
	logic signed [PW-1:0] pl_s66, ps_s66;
	logic                 zero_s66;

	always_ff @(posedge clk) begin
		pl_s66   <= $signed({1'b0, scale_q}) * vl_s65;
		ps_s66   <= $signed({1'b0, scale_q}) * vs_s65;
		zero_s66 <= zero_s65;
	end

	// -------------------------------------------------------------------------
	// Stage 67: numerator and denominator, floored at zero.
	// -------------------------------------------------------------------------
	logic signed [NX-1:0] num, den;

	always_comb begin
		num = $signed({{(NX-CPW){1'b0}}, ss256}) - NX'(pl_s66);
		den = $signed({{(NX-CPW){1'b0}}, ss256}) - NX'(ps_s66);
	end

	logic [NDW-1:0] un_s67, ud_s67;
	logic           zero_s67;

	always_ff @(posedge clk) begin
		un_s67   <= num[NX-1] ? '0 : num[NDW-1:0];
		ud_s67   <= den[NX-1] ? '0 : den[NDW-1:0];
		zero_s67 <= zero_s66;
	end

	// -------------------------------------------------------------------------
	// Stage 68: range checks ahead of the pitch division.
	// -------------------------------------------------------------------------
	logic [NDW-1:0]   un_s68, ud_s68;
	dpf_pkg::pq_sb_t  pq_s68;

	always_ff @(posedge clk) begin
		un_s68        <= un_s67;
		ud_s68        <= ud_s67;
		pq_s68.zero   <= zero_s67;
		pq_s68.sat_hi <= (ud_s67 == '0) || ({1'b0, un_s67} > {ud_s67, 1'b0});
		pq_s68.sat_lo <= ({un_s67, 1'b0} < {1'b0, ud_s67});
	end

	// -------------------------------------------------------------------------
	// Pitch division N*2^14 / D. In range N <= 2D, so N/4 already sits below D.
	// -------------------------------------------------------------------------
	logic [NDW-1:0]  pq_rem [PQW+1];
	logic [NDW-1:0]  pq_dvs [PQW+1];
	logic [PQW-1:0]  pq_nq  [PQW+1];
	dpf_pkg::pq_sb_t pq_sb_q [PQW];

	assign pq_rem[0] = un_s68 >> 2;
	assign pq_dvs[0] = ud_s68;
	assign pq_nq[0]  = {un_s68[1:0], {(PQW-2){1'b0}}};

	for (genvar k = 0; k < PQW; k++) begin : g_pitch
		dpf_div_cell #(
			.DW(NDW),
			.NW(PQW)
		) u_cell (
			.clk   (clk),
			.rem_in(pq_rem[k]),
			.dvs_in(pq_dvs[k]),
			.nq_in (pq_nq[k]),
			.rem_q (pq_rem[k+1]),
			.dvs_q (pq_dvs[k+1]),
			.nq_q  (pq_nq[k+1])
		);
	end

	always_ff @(posedge clk) begin
		pq_sb_q[0] <= pq_s68;
		for (int k = 1; k < PQW; k++)
			pq_sb_q[k] <= pq_sb_q[k-1];
	end

	// -------------------------------------------------------------------------
	// Result register: pick the special cases in priority order.
	// -------------------------------------------------------------------------
	dpf_pkg::res_t res_n;
	dpf_pkg::res_t res_q;
	logic          done_q;

	always_comb begin
		if (scale_q == '0 || pq_sb_q[PQW-1].zero) begin
			res_n.pitch_factor = dpf_pkg::PITCH_ONE;
			res_n.clamped      = 1'b0;
		end else if (pq_sb_q[PQW-1].sat_hi) begin
			res_n.pitch_factor = dpf_pkg::PITCH_MAX;
			res_n.clamped      = 1'b1;
		end else if (pq_sb_q[PQW-1].sat_lo) begin
			res_n.pitch_factor = dpf_pkg::PITCH_MIN;
			res_n.clamped      = 1'b1;
		end else begin
			res_n.pitch_factor = pq_nq[PQW];
			res_n.clamped      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[VLD_N-1];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// an index past the last register; the block must ignore writes to it
	localparam logic [3:0] CFG_SPARE = 4'd12;
	localparam int LATENCY   = 85;
	localparam int CYC_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 280;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	dpf_pkg::src_t   src;
	logic            done;
	dpf_pkg::res_t   res;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [3:0]      cfg_index;
	logic [31:0]     cfg_data;

	doppler_pitch_factor DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .src(src),
		.done(done), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the listener and doppler registers
	longint lis_pos [3];
	longint lis_vel [3];
	longint speed_q;
	longint dscale;

	dpf_pkg::res_t pitch_due [$];   // pitch results still awaited, oldest first
	int   mismatches = 0;
	bit   failed = 1'b0;
	int   cycles = 0;
	bit   idle_on;         // random gaps between transactions

	// one directed row: expected result typed in only where it is obvious
	typedef struct {
		dpf_pkg::src_t q;
		bit            typed;
		dpf_pkg::res_t want;
	} probe_t;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop on a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic longint sext(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// pitch ratio heard by the listener for one source query
	function automatic dpf_pkg::res_t predict_pitch(dpf_pkg::src_t q);
		dpf_pkg::res_t r;
		longint unsigned m [3];
		bit neg [3];
		longint sv [3], sl [3];
		longint unsigned top, sumsq, len;
		longint dot_l, dot_s, vls, vss, cap, ss256, n, dn, diff;
		longint unsigned un, ud;
		logic [31:0] pos [3];
		pos[0] = q.src_pos_x; pos[1] = q.src_pos_y; pos[2] = q.src_pos_z;
		sv[0] = sext(q.src_vel_x); sv[1] = sext(q.src_vel_y); sv[2] = sext(q.src_vel_z);
		r.pitch_factor = dpf_pkg::PITCH_ONE;
		r.clamped = 1'b0;
		if (dscale == 0)
			return r;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			diff = lis_pos[i] - sext(pos[i]);
			neg[i] = diff < 0;
			m[i] = neg[i] ? longint'(-diff) : longint'(diff);
			if (m[i] > top)
				top = m[i];
		end
		if (top == 0)
			return r;
		// bring the largest component into [2^23, 2^24)
		while (top >= (64'd1 << 24)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (top < (64'd1 << 23)) begin
			top <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			sl[i] = neg[i] ? -longint'(m[i]) : longint'(m[i]);
			sumsq += m[i] * m[i];
		end
		len = int_sqrt(sumsq);
		dot_l = 0;
		dot_s = 0;
		for (int i = 0; i < 3; i++) begin
			dot_l += sl[i] * lis_vel[i];
			dot_s += sl[i] * sv[i];
		end
		vls = dot_l / longint'(len);
		vss = dot_s / longint'(len);
		ss256 = speed_q * 256;
		cap = ss256 / dscale;
		if (vls > cap) vls = cap;
		if (vss > cap) vss = cap;
		n  = ss256 - dscale * vls;
		dn = ss256 - dscale * vss;
		un = n < 0 ? 0 : n;
		ud = dn < 0 ? 0 : dn;
		if (ud == 0 || un > 2 * ud) begin
			r.pitch_factor = dpf_pkg::PITCH_MAX;
			r.clamped = 1'b1;
		end else if (2 * un < ud) begin
			r.pitch_factor = dpf_pkg::PITCH_MIN;
			r.clamped = 1'b1;
		end else begin
			r.pitch_factor = dpf_pkg::PITCH_W'((un << 14) / ud);
		end
		return r;
	endfunction

	// register write; hold valid until the channel takes it
	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dpf_pkg::CFG_LPOS_X, dpf_pkg::CFG_LPOS_Y, dpf_pkg::CFG_LPOS_Z:
				lis_pos[idx] = sext(val);
			dpf_pkg::CFG_LVEL_X, dpf_pkg::CFG_LVEL_Y, dpf_pkg::CFG_LVEL_Z:
				lis_vel[idx - dpf_pkg::CFG_LVEL_X] = sext(val);
			dpf_pkg::CFG_SPEED:   speed_q = val[30:0];
			dpf_pkg::CFG_DOPPLER: dscale  = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one query; record what it should produce once it is taken
	task automatic send_query(dpf_pkg::src_t q, bit typed, dpf_pkg::res_t want);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		src   <= q;
		do @(posedge clk); while (busy);
		pitch_due.push_back(typed ? want : predict_pitch(q));
	endtask

	// drain: lower start, wait for every awaited result, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		wait (pitch_due.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// broad values: random width, random sign, with extremes now and then
	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: begin
				logic [31:0] v;
				v = $urandom >> $urandom_range(0, 31);
				return $urandom_range(0, 1) ? -v : v;
			end
		endcase
	endfunction

	// velocity in a band where the ratio often stays unclamped
	function automatic logic [31:0] soft_vel();
		logic [31:0] v;
		v = $urandom_range(0, 32'h0800_0000) >> $urandom_range(0, 12);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic random_queries(int count);
		dpf_pkg::src_t q;
		dpf_pkg::res_t none;
		none = '0;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				q = {any_word(), any_word(), any_word(), any_word(), any_word(), any_word()};
			end else begin
				// source close to the listener with moderate speed
				q.src_pos_x = 32'(lis_pos[0]) + soft_vel();
				q.src_pos_y = 32'(lis_pos[1]) + soft_vel();
				q.src_pos_z = 32'(lis_pos[2]) + soft_vel();
				q.src_vel_x = soft_vel();
				q.src_vel_y = soft_vel();
				q.src_vel_z = soft_vel();
			end
			send_query(q, 1'b0, none);
		end
	endtask

	// checker: every strobe must match the oldest awaited result
	always @(posedge clk) begin
		dpf_pkg::res_t exp_r;
		if (arst_n && done) begin
			if (pitch_due.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result pitch=%0d clamped=%0b",
						res.pitch_factor, res.clamped);
			end else begin
				exp_r = pitch_due.pop_front();
				if (res.pitch_factor !== exp_r.pitch_factor || res.clamped !== exp_r.clamped) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("pitch mismatch: want %0d/%0b got %0d/%0b",
							exp_r.pitch_factor, exp_r.clamped,
							res.pitch_factor, res.clamped);
				end
			end
		end
	end

	initial begin
		probe_t rows [$];
		probe_t p;
		dpf_pkg::res_t unity, none;
		unity.pitch_factor = dpf_pkg::PITCH_ONE;
		unity.clamped = 1'b0;
		none = '0;

		start = 1'b0;
		src = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		for (int i = 0; i < 3; i++) begin
			lis_pos[i] = 0;
			lis_vel[i] = 0;
		end
		speed_q = dpf_pkg::SOUND_SPEED_RST;
		dscale = 0;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// doppler disabled after reset: every query reads as unity
		p.typed = 1'b1; p.want = unity;
		p.q = {6{32'h8000_0000}}; rows.push_back(p);
		p.q = {6{32'h7FFF_FFFF}}; rows.push_back(p);
		p.q = '0;                  rows.push_back(p);
		foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);
		drain();

		// doppler on at 1.0, listener at rest at the origin
		write_reg(dpf_pkg::CFG_DOPPLER, 32'h0000_0100);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		rows.delete();
		p.typed = 1'b1; p.want = unity;
		p.q = '0; rows.push_back(p);                               // zero distance
		p.q = {32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1};
		rows.push_back(p);                                         // zero distance, moving
		p.typed = 1'b0; p.want = none;
		p.q = {32'h0000_1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}; rows.push_back(p);
		p.q = {32'h0000_1000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0}; rows.push_back(p);
		p.q = {32'h0000_1000, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0}; rows.push_back(p);
		p.q = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h0100_0000, 32'h0100_0000, 32'h0100_0000}; rows.push_back(p);
		p.q = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFF00_0000, 32'd5, 32'd0}; rows.push_back(p);
		p.q = {32'd0, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'h0400_0000, 32'd0}; rows.push_back(p);
		p.q = {32'd1, 32'd0, 32'd0, 32'hF800_0000, 32'd0, 32'd0}; rows.push_back(p);
		p.q = {32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'h0200_0000}; rows.push_back(p);
		p.q = {32'd3, 32'hFFFF_FFFD, 32'd7, 32'h0001_0000, 32'hFFFF_0000, 32'd0};
		rows.push_back(p);
		foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);
		random_queries(RAND_PER_PHASE);
		drain();

		// moving listener, extreme scale and speed
		write_reg(dpf_pkg::CFG_LPOS_X, 32'h8000_0000);
		write_reg(dpf_pkg::CFG_LPOS_Y, 32'h7FFF_FFFF);
		write_reg(dpf_pkg::CFG_LPOS_Z, 32'h0000_0000);
		write_reg(dpf_pkg::CFG_LVEL_X, 32'h7FFF_FFFF);
		write_reg(dpf_pkg::CFG_LVEL_Y, 32'h8000_0000);
		write_reg(dpf_pkg::CFG_LVEL_Z, 32'h0001_2345);
		write_reg(dpf_pkg::CFG_SPEED, 32'hFFFF_FFFF);
		write_reg(dpf_pkg::CFG_DOPPLER, 32'h0000_FFFF);
		random_queries(RAND_PER_PHASE);
		drain();

		// silent medium: zero sound speed, smallest scale
		write_reg(dpf_pkg::CFG_SPEED, 32'd0);
		write_reg(dpf_pkg::CFG_DOPPLER, 32'd1);
		random_queries(RAND_PER_PHASE / 2);
		drain();

		// random settings, twice; the last one runs flat out
		for (int ph = 0; ph < 2; ph++) begin
			write_reg(dpf_pkg::CFG_LPOS_X, soft_vel());
			write_reg(dpf_pkg::CFG_LPOS_Y, any_word());
			write_reg(dpf_pkg::CFG_LPOS_Z, soft_vel());
			write_reg(dpf_pkg::CFG_LVEL_X, soft_vel());
			write_reg(dpf_pkg::CFG_LVEL_Y, soft_vel());
			write_reg(dpf_pkg::CFG_LVEL_Z, soft_vel());
			write_reg(dpf_pkg::CFG_SPEED,
				dpf_pkg::SOUND_SPEED_RST + $urandom_range(0, 32'h0100_0000));
			write_reg(dpf_pkg::CFG_DOPPLER, $urandom_range(32'h40, 32'h400));
			idle_on = (ph == 0);
			random_queries(RAND_PER_PHASE);
			drain();
		end

		if (!failed) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/dpf_pkg.sv
design/dpf_div_cell.sv
design/dpf_sqrt_cell.sv
design/doppler_pitch_factor.sv
tb/tb_top.sv
